FILE: rtl/frt_pkg.sv
// ----------------------------------------------------------------------------
// Frame quarter-turn rotator package
// Types and constants shared by the rotator modules.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int DIM_BITS     = 7;
  localparam int PIX_OUT_BITS = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 7;

  // Bit positions inside the master-side tuser.
  localparam int USER_ROW_END = 0;
  localparam int USER_READY   = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_QUARTER_TURNS = 2'd2,
    REG_TURN_LEFT     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] frame_width;
    logic [DIM_BITS-1:0] frame_height;
    logic [1:0]          quarter_turns;
    logic                turn_left;
  } frt_cfg_t;

  typedef struct packed {
    logic load;
    logic read;
    logic restart;
  } frt_cmd_t;

  typedef struct packed {
    logic                ready;
    logic                row_end;
    logic                frame_end;
    logic [DIM_BITS-1:0] out_width;
    logic [DIM_BITS-1:0] out_height;
  } frt_meta_t;

endpackage

FILE: rtl/frt_store.sv
// ----------------------------------------------------------------------------
// Frame store
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
module frt_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/frt_addr.sv
// ----------------------------------------------------------------------------
// Frame rotator address generator
// Keeps the load count and the output raster position, and maps each
// output position to the source pixel address for the current rotation.
// ----------------------------------------------------------------------------
module frt_addr #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int AW         = 12,
  parameter int LW         = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  frt_pkg::frt_cfg_t    cfg,
  input  frt_pkg::frt_cmd_t    cmd,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  output frt_pkg::frt_meta_t   meta
);
  import frt_pkg::*;

  localparam int PW   = 2 * DIM_BITS;
  localparam int CW   = (LW > PW) ? LW : PW;
  localparam int DMAX = (1 << DIM_BITS) - 1;
  localparam int WMAX = (MAX_WIDTH < DMAX) ? MAX_WIDTH : DMAX;
  localparam int HMAX = (MAX_HEIGHT < DMAX) ? MAX_HEIGHT : DMAX;

  logic [LW-1:0]       load_count;
  logic [DIM_BITS-1:0] read_row;
  logic [DIM_BITS-1:0] read_col;

  logic [DIM_BITS-1:0] w, h, ow, oh, r, c, src_row, src_col;
  logic [1:0]          turns;
  logic [PW-1:0]       total, idx;
  logic                full, row_end, frame_end;

  always_comb begin
    if (cfg.frame_width == '0) begin
      w = DIM_BITS'(1);
    end else if (cfg.frame_width > DIM_BITS'(WMAX)) begin
      w = DIM_BITS'(WMAX);
    end else begin
      w = cfg.frame_width;
    end
    if (cfg.frame_height == '0) begin
      h = DIM_BITS'(1);
    end else if (cfg.frame_height > DIM_BITS'(HMAX)) begin
      h = DIM_BITS'(HMAX);
    end else begin
      h = cfg.frame_height;
    end
  end

  // A left turn of q is the right turn of -q modulo four.
  assign turns = cfg.turn_left ? 2'(~cfg.quarter_turns + 2'd1) : cfg.quarter_turns;
  assign ow    = turns[0] ? h : w;
  assign oh    = turns[0] ? w : h;
  assign total = PW'(w) * PW'(h);
  assign full  = CW'(load_count) >= CW'(total);

  assign r = (read_row < oh) ? read_row : oh - DIM_BITS'(1);
  assign c = (read_col < ow) ? read_col : ow - DIM_BITS'(1);

  always_comb begin
    unique case (turns)
      2'd0: begin
        src_row = r;
        src_col = c;
      end
      2'd1: begin
        src_row = h - DIM_BITS'(1) - c;
        src_col = r;
      end
      2'd2: begin
        src_row = h - DIM_BITS'(1) - r;
        src_col = w - DIM_BITS'(1) - c;
      end
      default: begin
        src_row = c;
        src_col = w - DIM_BITS'(1) - r;
      end
    endcase
  end

  assign idx       = PW'(src_row) * PW'(w) + PW'(src_col);
  assign row_end   = (c == ow - DIM_BITS'(1));
  assign frame_end = row_end && (r == oh - DIM_BITS'(1));

  assign wr_en   = cmd.load && !full;
  assign wr_addr = AW'(load_count);
  assign rd_en   = cmd.read && full;
  assign rd_addr = AW'(idx);

  assign meta.ready      = full;
  assign meta.row_end    = full && row_end;
  assign meta.frame_end  = full && frame_end;
  assign meta.out_width  = ow;
  assign meta.out_height = oh;

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      load_count <= '0;
      read_row   <= '0;
      read_col   <= '0;
    end else if (wr_en) begin
      load_count <= load_count + LW'(1);
    end else if (rd_en) begin
      if (frame_end) begin
        load_count <= '0;
        read_row   <= '0;
        read_col   <= '0;
      end else if (row_end) begin
        read_row <= r + DIM_BITS'(1);
        read_col <= '0;
      end else begin
        read_row <= r;
        read_col <= c + DIM_BITS'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(load_count) <= CW'(total))
    else $error("load count ran past the frame size");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    full |-> (read_row < oh) && (read_col < ow))
    else $error("read position left the rotated frame");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    rd_en && frame_end && !cmd.restart |=> load_count == '0 && read_row == '0)
    else $error("frame end did not restart the frame");

endmodule

FILE: rtl/frame_quarter_turn_rotator_top.sv
// ----------------------------------------------------------------------------
// Frame quarter-turn rotator, top level
// Loads a frame into a memory in raster order and reads it back rotated.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle, loads and reads alike, while the output is not
// stalled; the frame memory takes one write and one read per cycle.
// Output path: a load gives no output beat; an accepted read beat fills the memory
// read register and the read stage, then moves into the output register and shows
// on m_tvalid once that register is free.
// Reset clears counters, pipeline valids and the registers (width 1, height 1,
// no turn); memory contents stay undefined and need no clearing pass.
module frame_quarter_turn_rotator_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int PIXEL_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,   // [31:0] pixel_in
  input  logic                              s_tuser,   // [0] action
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [47:0]                       m_tdata,   // [31:0] pixel_out,
                                                       // [38:32] out_width,
                                                       // [45:39] out_height
  output logic                              m_tlast,   // frame_end
  output logic [1:0]                        m_tuser,   // [0] row_end, [1] ready_res
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [frt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [frt_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import frt_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(DEPTH + 1);

  frt_cfg_t  cfg;
  frt_cmd_t  cmd;
  frt_meta_t meta, b_meta;

  logic                  wr_en, rd_en, in_acc, out_free, b_valid;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [PIXEL_BITS-1:0] rd_data;
  logic [31:0]           pix_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= DIM_BITS'(1);
      cfg.frame_height  <= DIM_BITS'(1);
      cfg.quarter_turns <= '0;
      cfg.turn_left     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data;
        REG_QUARTER_TURNS: cfg.quarter_turns <= cfg_data[1:0];
        REG_TURN_LEFT:     cfg.turn_left     <= cfg_data[0];
        default:           cfg.turn_left     <= cfg.turn_left;
      endcase
    end
  end

  // The read stage may hand its beat to the output register in the same
  // cycle that a new read enters it.
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !b_valid || out_free;
  assign in_acc   = s_tvalid && s_tready;

  assign cmd.load    = in_acc && (action_t'(s_tuser) == ACT_LOAD);
  assign cmd.read    = in_acc && (action_t'(s_tuser) == ACT_READ);
  assign cmd.restart = cfg_valid && cfg_ready;

  frt_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW),
    .LW         (LW)
  ) u_addr (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .meta    (meta)
  );

  // A read is only issued once every pixel of the frame is written, and a
  // write always lands before any read of it, so no forwarding.
  frt_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (PIXEL_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (PIXEL_BITS'(s_tdata)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (cmd.read) begin
      b_valid <= 1'b1;
    end else if (out_free) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      b_meta <= meta;
    end
  end

  assign pix_out = b_meta.ready ? 32'(rd_data) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && b_valid) begin
      m_tdata               <= {2'b00, b_meta.out_height, b_meta.out_width, pix_out};
      m_tlast               <= b_meta.frame_end;
      m_tuser[USER_ROW_END] <= b_meta.row_end;
      m_tuser[USER_READY]   <= b_meta.ready;
    end
  end

  a_last_ends_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[USER_ROW_END])
    else $error("frame end without row end");

  a_not_ready_blank: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[USER_READY]
      |-> m_tdata[31:0] == '0 && !m_tlast && !m_tuser[USER_ROW_END])
    else $error("incomplete-frame beat carries pixel data");

  a_read_fills_stage: assert property (@(posedge clk) disable iff (rst)
    cmd.read |=> b_valid)
    else $error("accepted read did not reach the read stage");

  a_out_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(b_valid))
    else $error("output beat without a read stage beat");

endmodule

FILE: tb/sv/frame_quarter_turn_rotator_top_test.sv
// ----------------------------------------------------------------------------
// Frame quarter-turn rotator testbench
// Streams load and read beats into the rotator under random source gaps and
// sink stalls, runs a software copy of the rotation alongside, and compares
// every output beat field by field against that prediction.
// ----------------------------------------------------------------------------
module frame_quarter_turn_rotator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import frt_pkg::*;

  localparam int MAX_W = 64;
  localparam int MAX_H = 64;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_BEATS = 650;
  localparam int WIDE_ROWS = 4;

  typedef struct packed {
    logic [31:0]         pixel;
    logic                row_end;
    logic                frame_end;
    logic                ready;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
  } rot_pixel_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [31:0]              s_tdata = '0;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [47:0]              m_tdata;
  logic                     m_tlast;
  logic [1:0]               m_tuser;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  frame_quarter_turn_rotator_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .PIXEL_BITS(32)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Software copy of the rotator state.
  logic [31:0]         frame_mem [0:MAX_W*MAX_H-1];
  int unsigned         loaded;
  int unsigned         out_row;
  int unsigned         out_col;
  logic [DIM_BITS-1:0] width_reg;
  logic [DIM_BITS-1:0] height_reg;
  logic [1:0]          turns_reg;
  logic                left_reg;

  rot_pixel_t  expected_pixels [$];
  int unsigned mismatches;
  int unsigned beats_sent;
  bit          tx_gaps_on;
  bit          rx_stalls_on;
  int unsigned rx_hold;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int unsigned draw_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [31:0] draw_pixel();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned clamp_dim(logic [DIM_BITS-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned frame_pixels();
    return clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
  endfunction

  task automatic restart_frame();
    loaded = 0;
    out_row = 0;
    out_col = 0;
  endtask

  // Works out what one accepted beat does to the frame and what it returns.
  task automatic predict_rotation(action_t act, logic [31:0] pix);
    int unsigned w, h, turns, ow, oh, r, c, src_r, src_c;
    rot_pixel_t  res;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    turns = left_reg ? ((4 - turns_reg) & 3) : turns_reg;
    ow = turns[0] ? h : w;
    oh = turns[0] ? w : h;
    if (act == ACT_LOAD) begin
      // A load into a full frame is dropped.
      if (loaded < w * h) begin
        frame_mem[loaded] = pix;
        loaded++;
      end
      return;
    end
    res = '0;
    res.width = ow[DIM_BITS-1:0];
    res.height = oh[DIM_BITS-1:0];
    if (loaded < w * h) begin
      expected_pixels.push_back(res);
      return;
    end
    r = (out_row < oh) ? out_row : oh - 1;
    c = (out_col < ow) ? out_col : ow - 1;
    case (turns)
      0: begin
        src_r = r;
        src_c = c;
      end
      1: begin
        src_r = h - 1 - c;
        src_c = r;
      end
      2: begin
        src_r = h - 1 - r;
        src_c = w - 1 - c;
      end
      default: begin
        src_r = c;
        src_c = w - 1 - r;
      end
    endcase
    res.pixel = frame_mem[src_r * w + src_c];
    res.row_end = (c == ow - 1);
    res.frame_end = res.row_end && (r == oh - 1);
    res.ready = 1'b1;
    expected_pixels.push_back(res);
    if (res.frame_end) begin
      restart_frame();
    end else if (res.row_end) begin
      out_col = 0;
      out_row = r + 1;
    end else begin
      out_col = c + 1;
      out_row = r;
    end
  endtask

  task automatic send_beat(action_t act, logic [31:0] pix);
    int unsigned gap;
    gap = tx_gaps_on ? draw_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= $urandom;
      s_tuser <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_rotation(act, pix);
    beats_sent++;
  endtask

  task automatic read_pixels(int unsigned n);
    repeat (n) send_beat(ACT_READ, $urandom);
  endtask

  // Stops the stream and waits until the block has nothing left in flight.
  task automatic settle_stream();
    @(negedge clk);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
    settle_stream();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:   width_reg = value;
      REG_FRAME_HEIGHT:  height_reg = value;
      REG_QUARTER_TURNS: turns_reg = value[1:0];
      REG_TURN_LEFT:     left_reg = value[0];
      default: ;
    endcase
    restart_frame();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      rx_hold = rx_stalls_on ? draw_gap() : 0;
    end
  end

  always @(posedge clk) begin
    rot_pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual pixel %h", $time,
                 m_tdata[31:0]);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        compare_field("pixel_out", want.pixel, m_tdata[31:0]);
        compare_field("out_width", want.width, m_tdata[38:32]);
        compare_field("out_height", want.height, m_tdata[45:39]);
        compare_field("row_end", want.row_end, m_tuser[USER_ROW_END]);
        compare_field("ready_res", want.ready, m_tuser[USER_READY]);
        compare_field("frame_end", want.frame_end, m_tlast);
      end
    end
  end

  // Defaults after reset: a 1x1 frame with no turn.
  task automatic test_reset_state();
    read_pixels(1);
    send_beat(ACT_LOAD, 32'h8000_0000);
    send_beat(ACT_LOAD, 32'h7FFF_FFFF);
    read_pixels(2);
  endtask

  // A left turn, an early read, and a register write in the middle of a frame.
  task automatic test_turn_direction();
    write_reg(REG_FRAME_WIDTH, 7'd3);
    write_reg(REG_FRAME_HEIGHT, 7'd2);
    write_reg(REG_QUARTER_TURNS, 7'd1);
    write_reg(REG_TURN_LEFT, 7'd1);
    for (int k = 0; k < 6; k++) begin
      if (k == 3) read_pixels(1);
      send_beat(ACT_LOAD, draw_pixel());
    end
    read_pixels(6);
    repeat (6) send_beat(ACT_LOAD, draw_pixel());
    read_pixels(2);
    write_reg(REG_QUARTER_TURNS, 7'd2);
    read_pixels(1);
  endtask

  // A frame of full width, with the width register above the maximum.
  task automatic test_full_frame();
    write_reg(REG_FRAME_WIDTH, 7'd127);
    write_reg(REG_FRAME_HEIGHT, 7'(WIDE_ROWS));
    write_reg(REG_QUARTER_TURNS, 7'd1);
    write_reg(REG_TURN_LEFT, 7'd0);
    repeat (MAX_W * WIDE_ROWS) send_beat(ACT_LOAD, draw_pixel());
    read_pixels(MAX_W * WIDE_ROWS);
    write_reg(REG_FRAME_WIDTH, 7'd0);
    write_reg(REG_FRAME_HEIGHT, 7'd0);
    send_beat(ACT_LOAD, draw_pixel());
    read_pixels(1);
  endtask

  task automatic test_random_frames();
    int unsigned start, sel, frames, total, nread;
    logic [CFG_DATA_BITS-1:0] wv, hv, tmp;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        wv = 7'($urandom_range(1, 8));
        hv = 7'($urandom_range(1, 8));
      end else if (sel < 93) begin
        wv = 7'($urandom_range(1, 64));
        hv = 7'($urandom_range(1, 4));
      end else begin
        wv = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
        hv = 7'($urandom_range(0, 3));
      end
      if ($urandom_range(0, 1)) begin
        tmp = wv;
        wv = hv;
        hv = tmp;
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_WIDTH, wv);
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, hv);
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_QUARTER_TURNS, 7'($urandom_range(0, 127)));
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_TURN_LEFT, 7'($urandom_range(0, 127)));
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        total = frame_pixels();
        for (int k = 0; k < total; k++) begin
          if ($urandom_range(0, 99) < 3) read_pixels(1);
          send_beat(ACT_LOAD, draw_pixel());
        end
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) send_beat(ACT_LOAD, draw_pixel());
        end
        nread = total;
        // Now and then the frame is abandoned part way through its readout.
        if (f == frames - 1 && $urandom_range(0, 99) < 15) nread = $urandom_range(0, total - 1);
        read_pixels(nread);
      end
    end
  endtask

  initial begin
    mismatches = 0;
    beats_sent = 0;
    rx_hold = 0;
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    width_reg = 7'd1;
    height_reg = 7'd1;
    turns_reg = 2'd0;
    left_reg = 1'b0;
    restart_frame();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_turn_direction();
    test_full_frame();
    test_random_frames();
    settle_stream();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("frame_quarter_turn_rotator_top_test OK");
    end else begin
      $display("frame_quarter_turn_rotator_top_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("frame_quarter_turn_rotator_top_test NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/frt_pkg.sv
rtl/frt_store.sv
rtl/frt_addr.sv
rtl/frame_quarter_turn_rotator_top.sv
tb/sv/frame_quarter_turn_rotator_top_test.sv
